### src/ipv4_header_checker_macros.svh
// ----------------------------------------------------------------------------
// IPv4 header checker assertion macros
// Shorthand for the clocked implication properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_CHECKER_MACROS_SVH
`define IPV4_HEADER_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv4 header checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define IHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv4 header checker: next-cycle property failed");

`endif

### src/ipv4hc_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header checker package
// Shared constants, status codes and record types.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hc_pkg;

    localparam logic [15:0] HDR_LEN   = 16'd20;
    localparam logic [7:0]  VER_IHL   = 8'h45;
    localparam logic [15:0] OFF_MASK  = 16'h1FFF;
    localparam logic [15:0] MF_BIT    = 16'h2000;
    localparam logic [15:0] WORD_MASK = 16'hFFFF;
    localparam logic [4:0]  PAYLOAD_OFFSET = 5'd20;

    typedef logic [2:0] t_status;

    localparam t_status STATUS_OK        = 3'd0;
    localparam t_status STATUS_SHORT     = 3'd1;
    localparam t_status STATUS_VERSION   = 3'd2;
    localparam t_status STATUS_TOTAL_LEN = 3'd3;
    localparam t_status STATUS_FRAGMENT  = 3'd4;
    localparam t_status STATUS_CHECKSUM  = 3'd5;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [7:0]  first_byte;
        logic [15:0] total_length;
        logic [15:0] flag_word;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [16:0] sum;
        logic [7:0]  high_byte;
    } t_frame;

    typedef struct packed {
        t_status     status;
        logic [31:0] source_address;
        logic [7:0]  protocol;
        logic [15:0] payload_length;
        logic [4:0]  payload_offset;
        logic        fragment;
    } t_verdict;

endpackage

`default_nettype wire

### src/ipv4hc_capture.sv
// ----------------------------------------------------------------------------
// IPv4 header checker frame capture
// Holds the per-frame header fields and running checksum, and presents the
// frame state as it stands after the byte at the input.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_capture
    import ipv4hc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output t_frame          o_next
);

    t_frame r_frame;
    t_frame n_frame;

    logic        w_in_hdr;
    logic [4:0]  w_idx;
    logic [17:0] w_sum_wide;
    logic [16:0] w_sum_fold;

    assign w_in_hdr   = r_frame.byte_count < HDR_LEN;
    assign w_idx      = r_frame.byte_count[4:0];
    assign w_sum_wide = {1'b0, r_frame.sum} + {2'b00, r_frame.high_byte, i_data_byte};
    assign w_sum_fold = {1'b0, w_sum_wide[15:0]} + {15'd0, w_sum_wide[17:16]};

    always_comb begin
        n_frame = r_frame;
        if (r_frame.byte_count != WORD_MASK) begin
            n_frame.byte_count = r_frame.byte_count + 16'd1;
        end
        if (w_in_hdr) begin
            if (w_idx == 5'd0) begin
                n_frame.first_byte = i_data_byte;
            end
            if (w_idx == 5'd2 || w_idx == 5'd3) begin
                n_frame.total_length = {r_frame.total_length[7:0], i_data_byte};
            end
            if (w_idx == 5'd6 || w_idx == 5'd7) begin
                n_frame.flag_word = {r_frame.flag_word[7:0], i_data_byte};
            end
            if (w_idx == 5'd9) begin
                n_frame.protocol = i_data_byte;
            end
            if (w_idx >= 5'd12 && w_idx <= 5'd15) begin
                n_frame.source = {r_frame.source[23:0], i_data_byte};
            end
            if (w_idx[0] == 1'b0) begin
                n_frame.high_byte = i_data_byte;
            end else begin
                n_frame.sum = w_sum_fold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_take) begin
            if (i_last_byte) begin
                r_frame <= '0;
            end else begin
                r_frame <= n_frame;
            end
        end
    end

    assign o_next = n_frame;

endmodule

`default_nettype wire

### src/ipv4hc_verdict.sv
// ----------------------------------------------------------------------------
// IPv4 header checker verdict logic
// Runs the ordered header checks on a completed frame and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_verdict
    import ipv4hc_pkg::*;
(
    input  wire t_frame i_frame,
    output t_verdict    o_verdict
);

    logic w_is_frag;

    assign w_is_frag = ((i_frame.flag_word & OFF_MASK) != 16'd0)
                    || ((i_frame.flag_word & MF_BIT) != 16'd0);

    always_comb begin
        o_verdict = '0;
        priority if (i_frame.byte_count < HDR_LEN) begin
            o_verdict.status = STATUS_SHORT;
        end else if (i_frame.first_byte != VER_IHL) begin
            o_verdict.status = STATUS_VERSION;
        end else if (i_frame.total_length < HDR_LEN
                  || i_frame.total_length > i_frame.byte_count) begin
            o_verdict.status = STATUS_TOTAL_LEN;
        end else if (w_is_frag) begin
            o_verdict.status   = STATUS_FRAGMENT;
            o_verdict.fragment = 1'b1;
        end else if (i_frame.sum != {1'b0, WORD_MASK}) begin
            o_verdict.status = STATUS_CHECKSUM;
        end else begin
            o_verdict.status         = STATUS_OK;
            o_verdict.source_address = i_frame.source;
            o_verdict.protocol       = i_frame.protocol;
            o_verdict.payload_length = i_frame.total_length - HDR_LEN;
            o_verdict.payload_offset = PAYLOAD_OFFSET;
        end
    end

endmodule

`default_nettype wire

### src/ipv4hc_result.sv
// ----------------------------------------------------------------------------
// IPv4 header checker result stage
// Keeps the fragment drop counter and the output register of the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_result
    import ipv4hc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_verdict i_verdict,
    input  wire logic  i_ready,
    output logic       o_free,
    output logic       o_valid,
    output t_status    o_status,
    output logic [31:0] o_source_address,
    output logic [7:0] o_protocol,
    output logic [15:0] o_payload_length,
    output logic [4:0] o_payload_offset,
    output logic [31:0] o_fragments_dropped
);

    logic        r_valid;
    logic [31:0] r_drop;
    t_verdict    r_verdict;
    logic [31:0] r_dropped_out;
    logic [31:0] n_drop;

    assign n_drop = r_drop + {31'd0, i_verdict.fragment};
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_drop  <= '0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
                r_drop  <= n_drop;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict     <= i_verdict;
            r_dropped_out <= n_drop;
        end
    end

    assign o_valid             = r_valid;
    assign o_status            = r_verdict.status;
    assign o_source_address    = r_verdict.source_address;
    assign o_protocol          = r_verdict.protocol;
    assign o_payload_length    = r_verdict.payload_length;
    assign o_payload_offset    = r_verdict.payload_offset;
    assign o_fragments_dropped = r_dropped_out;

endmodule

`default_nettype wire

### src/ipv4_header_checker.sv
// ----------------------------------------------------------------------------
// IPv4 header checker
// Streams a frame byte by byte and gives one header verdict per frame.
//
//   Channel   Direction   Handshake            Payload
//   input     in          i_valid / o_ready    i_data_byte, i_last_byte
//   result    out         o_valid / i_ready    status, address, protocol,
//                                              lengths, drop count
//
// One byte is taken every cycle, a rate set by the input register feeding
// the capture and verdict logic, while no last byte waits on a full result.
// The verdict is registered as its last byte leaves the input register.
// Reset clears the frame state, the drop counter and both valid flags.
// Bytes stall only while a last byte waits for a full result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_checker
    import ipv4hc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_source_address,
    output logic [7:0]       o_protocol,
    output logic [15:0]      o_payload_length,
    output logic [4:0]       o_payload_offset,
    output logic [31:0]      o_fragments_dropped
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    logic       w_out_free;
    logic       w_advance;
    t_frame     w_frame;
    t_verdict   w_verdict;

    assign w_advance = r_in_valid && (!r_in_last || w_out_free);
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ipv4hc_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_advance),
        .i_data_byte (r_in_data),
        .i_last_byte (r_in_last),
        .o_next      (w_frame)
    );

    ipv4hc_verdict u_verdict (
        .i_frame   (w_frame),
        .o_verdict (w_verdict)
    );

    ipv4hc_result u_result (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (w_advance && r_in_last),
        .i_verdict           (w_verdict),
        .i_ready             (i_ready),
        .o_free              (w_out_free),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_source_address    (o_source_address),
        .o_protocol          (o_protocol),
        .o_payload_length    (o_payload_length),
        .o_payload_offset    (o_payload_offset),
        .o_fragments_dropped (o_fragments_dropped)
    );

endmodule

`default_nettype wire

### src/ipv4hc_checker.sv
// ----------------------------------------------------------------------------
// IPv4 header checker port checker
// Watches the top-level ports for held results and consistent verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_header_checker_macros.svh"

module ipv4hc_checker
    import ipv4hc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_source_address,
    input wire logic [7:0]  o_protocol,
    input wire logic [15:0] o_payload_length,
    input wire logic [4:0]  o_payload_offset,
    input wire logic [31:0] o_fragments_dropped
);

    `IHC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_status) && $stable(o_source_address)
        && $stable(o_payload_length) && $stable(o_fragments_dropped))

    `IHC_ASSERT_IMP(a_ok_offset, i_clk, i_rst_n, o_valid && o_status == STATUS_OK,
        o_payload_offset == PAYLOAD_OFFSET && o_payload_length <= 16'd65515)

    `IHC_ASSERT_IMP(a_reject_zeroed, i_clk, i_rst_n, o_valid && o_status != STATUS_OK,
        o_source_address == 32'd0 && o_protocol == 8'd0
        && o_payload_length == 16'd0 && o_payload_offset == 5'd0)

    `IHC_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_status <= STATUS_CHECKSUM)

endmodule

bind ipv4_header_checker ipv4hc_checker u_ipv4hc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_status            (o_status),
    .o_source_address    (o_source_address),
    .o_protocol          (o_protocol),
    .o_payload_length    (o_payload_length),
    .o_payload_offset    (o_payload_offset),
    .o_fragments_dropped (o_fragments_dropped)
);

`default_nettype wire

### test/ipv4_header_checker_test.sv
// ----------------------------------------------------------------------------
// IPv4 header checker testbench
// Sends byte streams that hold IPv4 frames, some well formed and some broken
// in each way the checker recognizes, and compares every verdict field by
// field against a predictor of the header capture, the checksum and the
// fragment drop count. Both channels idle at random in several phases.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_checker_test;
    import ipv4hc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        t_status     status;
        logic [31:0] source_address;
        logic [7:0]  protocol;
        logic [15:0] payload_length;
        logic [4:0]  payload_offset;
        logic [31:0] fragments_dropped;
    } t_header_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_source_address;
    logic [7:0]  o_protocol;
    logic [15:0] o_payload_length;
    logic [4:0]  o_payload_offset;
    logic [31:0] o_fragments_dropped;

    ipv4_header_checker u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_source_address    (o_source_address),
        .o_protocol          (o_protocol),
        .o_payload_length    (o_payload_length),
        .o_payload_offset    (o_payload_offset),
        .o_fragments_dropped (o_fragments_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int gap_pct = 0;
    int stall_pct = 0;
    int err_count = 0;
    int bytes_sent = 0;
    int idle_cycles = 0;

    t_header_verdict pending_verdicts[$];
    logic [7:0]      frame_buf[$];

    logic [15:0] seen_count = '0;
    logic [7:0]  seen_first = '0;
    logic [15:0] seen_total = '0;
    logic [15:0] seen_flags = '0;
    logic [7:0]  seen_proto = '0;
    logic [31:0] seen_source = '0;
    logic [16:0] seen_sum = '0;
    logic [7:0]  seen_high = '0;
    logic [31:0] drops_seen = '0;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ipv4_header_checker_test NOT OK");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        t_header_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result transaction with no verdict expected");
                err_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (o_source_address !== want.source_address) begin
                    $error("source_address: expected %h, got %h",
                           want.source_address, o_source_address);
                    err_count++;
                end
                if (o_protocol !== want.protocol) begin
                    $error("protocol: expected %h, got %h", want.protocol, o_protocol);
                    err_count++;
                end
                if (o_payload_length !== want.payload_length) begin
                    $error("payload_length: expected %0d, got %0d",
                           want.payload_length, o_payload_length);
                    err_count++;
                end
                if (o_payload_offset !== want.payload_offset) begin
                    $error("payload_offset: expected %0d, got %0d",
                           want.payload_offset, o_payload_offset);
                    err_count++;
                end
                if (o_fragments_dropped !== want.fragments_dropped) begin
                    $error("fragments_dropped: expected %0d, got %0d",
                           want.fragments_dropped, o_fragments_dropped);
                    err_count++;
                end
            end
        end
    end

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        t_header_verdict v;
        logic [16:0]     s;
        if (seen_count < HDR_LEN) begin
            if (seen_count == 16'd0) seen_first = b;
            if (seen_count == 16'd2 || seen_count == 16'd3) seen_total = {seen_total[7:0], b};
            if (seen_count == 16'd6 || seen_count == 16'd7) seen_flags = {seen_flags[7:0], b};
            if (seen_count == 16'd9) seen_proto = b;
            if (seen_count >= 16'd12 && seen_count <= 16'd15) begin
                seen_source = {seen_source[23:0], b};
            end
            if (!seen_count[0]) begin
                seen_high = b;
            end else begin
                s = seen_sum + {1'b0, seen_high, b};
                seen_sum = {1'b0, s[15:0]} + {16'd0, s[16]};
            end
        end
        if (seen_count != 16'hFFFF) seen_count = seen_count + 16'd1;
        if (last) begin
            v.source_address = '0;
            v.protocol = '0;
            v.payload_length = '0;
            v.payload_offset = '0;
            if (seen_count < HDR_LEN) begin
                v.status = STATUS_SHORT;
            end else if (seen_first != VER_IHL) begin
                v.status = STATUS_VERSION;
            end else if (seen_total < HDR_LEN || seen_total > seen_count) begin
                v.status = STATUS_TOTAL_LEN;
            end else if ((seen_flags & (OFF_MASK | MF_BIT)) != 16'd0) begin
                v.status = STATUS_FRAGMENT;
                drops_seen = drops_seen + 32'd1;
            end else if (seen_sum != {1'b0, WORD_MASK}) begin
                v.status = STATUS_CHECKSUM;
            end else begin
                v.status = STATUS_OK;
                v.source_address = seen_source;
                v.protocol = seen_proto;
                v.payload_length = seen_total - HDR_LEN;
                v.payload_offset = PAYLOAD_OFFSET;
            end
            v.fragments_dropped = drops_seen;
            pending_verdicts.push_back(v);
            seen_count = '0;
            seen_first = '0;
            seen_total = '0;
            seen_flags = '0;
            seen_proto = '0;
            seen_source = '0;
            seen_sum = '0;
            seen_high = '0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int n;
        n = frame_buf.size();
        for (int k = 0; k < n; k++) begin
            send_byte(frame_buf[k], k == n - 1);
        end
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] clean_flags();
        return {2'($urandom_range(0, 3)), 14'd0};
    endfunction

    function automatic logic [15:0] fragment_flags();
        logic [15:0] f;
        f = {2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191))};
        if (f[13:0] == 14'd0) f[13] = 1'b1;
        return f;
    endfunction

    task automatic seal_header();
        logic [16:0] acc;
        logic [15:0] csum;
        acc = '0;
        frame_buf[10] = 8'd0;
        frame_buf[11] = 8'd0;
        for (int k = 0; k < 20; k += 2) begin
            acc = acc + {1'b0, frame_buf[k], frame_buf[k + 1]};
            acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
        end
        csum = ~acc[15:0];
        frame_buf[10] = csum[15:8];
        frame_buf[11] = csum[7:0];
    endtask

    task automatic build_header(input logic [15:0] total, input logic [15:0] flags,
                                input logic [7:0] proto);
        frame_buf.delete();
        frame_buf.push_back(VER_IHL);
        frame_buf.push_back(rand_byte());
        frame_buf.push_back(total[15:8]);
        frame_buf.push_back(total[7:0]);
        frame_buf.push_back(rand_byte());
        frame_buf.push_back(rand_byte());
        frame_buf.push_back(flags[15:8]);
        frame_buf.push_back(flags[7:0]);
        frame_buf.push_back(rand_byte());
        frame_buf.push_back(proto);
        frame_buf.push_back(8'd0);
        frame_buf.push_back(8'd0);
        for (int k = 0; k < 8; k++) frame_buf.push_back(rand_byte());
        seal_header();
    endtask

    task automatic add_payload(input int n);
        for (int k = 0; k < n; k++) frame_buf.push_back(rand_byte());
    endtask

    task automatic truncate_frame(input int n);
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
    endtask

    task automatic test_short_frames();
        frame_buf.delete();
        frame_buf.push_back(8'h00);
        send_frame();
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame();
        build_header(16'd20, clean_flags(), rand_byte());
        truncate_frame(19);
        send_frame();
        build_header(16'd20, clean_flags(), rand_byte());
        truncate_frame(2);
        send_frame();
    endtask

    task automatic test_version_field();
        logic [7:0] firsts[4];
        firsts = '{8'h00, 8'hFF, 8'h46, 8'h35};
        for (int k = 0; k < 4; k++) begin
            build_header(16'd20, clean_flags(), rand_byte());
            frame_buf[0] = firsts[k];
            send_frame();
        end
    endtask

    task automatic test_total_length();
        build_header(16'd0, clean_flags(), rand_byte());
        send_frame();
        build_header(16'd19, clean_flags(), rand_byte());
        send_frame();
        build_header(16'd20, clean_flags(), rand_byte());
        send_frame();
        build_header(16'd21, clean_flags(), rand_byte());
        send_frame();
        build_header(16'hFFFF, clean_flags(), rand_byte());
        send_frame();
        build_header(16'd30, clean_flags(), rand_byte());
        add_payload(20);
        send_frame();
    endtask

    task automatic test_fragment_flags();
        logic [15:0] flag_cases[6];
        flag_cases = '{16'h2000, 16'h0001, 16'h1FFF, 16'h4000, 16'h8000, 16'hFFFF};
        for (int k = 0; k < 6; k++) begin
            build_header(16'd24, flag_cases[k], rand_byte());
            add_payload(4);
            send_frame();
        end
    endtask

    task automatic test_checksum_and_fields();
        build_header(16'd20, clean_flags(), rand_byte());
        frame_buf[10] = frame_buf[10] ^ 8'h80;
        send_frame();
        build_header(16'd20, clean_flags(), rand_byte());
        frame_buf[19] = frame_buf[19] ^ 8'h01;
        send_frame();
        build_header(16'd20, clean_flags(), 8'hFF);
        for (int k = 12; k < 20; k++) frame_buf[k] = 8'hFF;
        seal_header();
        send_frame();
        build_header(16'd20, clean_flags(), 8'h00);
        for (int k = 12; k < 20; k++) frame_buf[k] = 8'h00;
        seal_header();
        send_frame();
    endtask

    task automatic test_long_frames();
        build_header(16'd120, clean_flags(), rand_byte());
        add_payload(100);
        send_frame();
        build_header(16'hFFFF, clean_flags(), rand_byte());
        add_payload(60);
        send_frame();
        build_header(16'd28, clean_flags(), rand_byte());
        add_payload(8);
        send_frame();
    endtask

    task automatic send_random_frame();
        int          kind;
        int          plen;
        int          n;
        logic [15:0] total;
        logic [7:0]  v;
        kind = $urandom_range(0, 9);
        plen = $urandom_range(0, 8);
        total = 16'(20 + $urandom_range(0, plen));
        case (kind)
            4: begin
                build_header(total, clean_flags(), rand_byte());
                truncate_frame($urandom_range(1, 19));
            end
            5: begin
                build_header(total, clean_flags(), rand_byte());
                v = rand_byte();
                if (v == VER_IHL) v = v ^ 8'h01;
                frame_buf[0] = v;
                add_payload(plen);
            end
            6: begin
                if ($urandom_range(0, 1) != 0) begin
                    total = 16'($urandom_range(0, 19));
                end else begin
                    total = 16'(20 + plen + $urandom_range(1, 65000));
                end
                build_header(total, clean_flags(), rand_byte());
                add_payload(plen);
            end
            7: begin
                build_header(total, fragment_flags(), rand_byte());
                add_payload(plen);
            end
            8: begin
                build_header(total, clean_flags(), rand_byte());
                n = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(10, 19);
                frame_buf[n] = frame_buf[n] ^ (8'd1 << $urandom_range(0, 7));
                add_payload(plen);
            end
            9: begin
                frame_buf.delete();
                add_payload($urandom_range(1, 30));
                if ($urandom_range(0, 1) != 0) frame_buf[0] = VER_IHL;
            end
            default: begin
                build_header(total, clean_flags(), rand_byte());
                add_payload(plen);
            end
        endcase
        send_frame();
    endtask

    task automatic test_random_frames(input int gap, input int stall, input int budget);
        int start;
        gap_pct = gap;
        stall_pct = stall;
        start = bytes_sent;
        while (bytes_sent - start < budget) send_random_frame();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_frames();
        test_version_field();
        test_total_length();
        test_fragment_flags();
        test_checksum_and_fields();
        test_long_frames();
        test_random_frames(0, 0, 100);
        test_random_frames(48, 0, 100);
        test_random_frames(0, 48, 100);
        test_random_frames(35, 35, 100);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ipv4_header_checker_test OK");
        end else begin
            $display("ipv4_header_checker_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/ipv4hc_pkg.sv
src/ipv4hc_capture.sv
src/ipv4hc_verdict.sv
src/ipv4hc_result.sv
src/ipv4_header_checker.sv
src/ipv4hc_checker.sv
test/ipv4_header_checker_test.sv
